// ----- design/mmbd_pkg.sv -----
// ----------------------------------------------------------------------------
// mmbd_pkg
// Types, unit codes and the boot program image shared by the bus decoder.
// ----------------------------------------------------------------------------
package mmbd_pkg;

	// Opcode codes
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Target unit codes
	localparam logic [3:0] UNIT_NONE = 4'd0;
	localparam logic [3:0] UNIT_CROM = 4'd1;
	localparam logic [3:0] UNIT_VRAM = 4'd2;
	localparam logic [3:0] UNIT_CRAM = 4'd3;
	localparam logic [3:0] UNIT_WRAM = 4'd4;
	localparam logic [3:0] UNIT_OAM  = 4'd5;
	localparam logic [3:0] UNIT_HRAM = 4'd6;
	localparam logic [3:0] UNIT_TMR  = 4'd7;
	localparam logic [3:0] UNIT_INT  = 4'd8;
	localparam logic [3:0] UNIT_VREG = 4'd9;

	// Fixed addresses and values
	localparam logic [15:0] ADDR_SERIAL_DATA = 16'hFF01;
	localparam logic [15:0] ADDR_SERIAL_CTRL = 16'hFF02;
	localparam logic [15:0] ADDR_BOOT_OFF    = 16'hFF50;
	localparam logic [15:0] ADDR_INT_ENABLE  = 16'hFFFF;
	localparam logic [15:0] ADDR_INT_FLAG    = 16'hFF0F;
	localparam logic [7:0]  SERIAL_START     = 8'h81;
	localparam logic [7:0]  OPEN_BUS         = 8'hFF;

	localparam int BOOT_ROM_BYTES = 256;

	// Input word
	typedef struct packed {
		logic        opcode;
		logic [15:0] address;
		logic [7:0]  write_data;
	} in_t;

	// Result word
	typedef struct packed {
		logic [3:0]  target_unit;
		logic [12:0] target_offset;
		logic        target_write;
		logic        local_valid;
		logic [7:0]  local_read_data;
		logic        serial_out_valid;
		logic [7:0]  serial_out_byte;
	} out_t;

	// Local state seen by the decoder
	typedef struct packed {
		logic       cart_present;
		logic       overlay_on;
		logic [7:0] ser_data;
		logic [7:0] serial_ctrl;
	} st_t;

	// State updates requested by the decoder
	typedef struct packed {
		logic clr_overlay;
		logic serial_data_we;
		logic serial_ctrl_we;
	} upd_t;

	// Boot program image
	localparam logic [7:0] BOOT_IMAGE [BOOT_ROM_BYTES] = '{
		8'h31, 8'hFE, 8'hFF, 8'hAF, 8'h21, 8'hFF, 8'h9F, 8'h32,
		8'hCB, 8'h7C, 8'h20, 8'hFB, 8'h21, 8'h26, 8'hFF, 8'h0E,
		8'h11, 8'h3E, 8'h80, 8'h32, 8'hE2, 8'h0C, 8'h3E, 8'hF3,
		8'hE2, 8'h32, 8'h3E, 8'h77, 8'h77, 8'h3E, 8'hFC, 8'hE0,
		8'h47, 8'h11, 8'h04, 8'h01, 8'h21, 8'h10, 8'h80, 8'h1A,
		8'hCD, 8'h95, 8'h00, 8'hCD, 8'h96, 8'h00, 8'h13, 8'h7B,
		8'hFE, 8'h34, 8'h20, 8'hF3, 8'h11, 8'hD8, 8'h00, 8'h06,
		8'h08, 8'h1A, 8'h13, 8'h22, 8'h23, 8'h05, 8'h20, 8'hF9,
		8'h3E, 8'h19, 8'hEA, 8'h10, 8'h99, 8'h21, 8'h2F, 8'h99,
		8'h0E, 8'h0C, 8'h3D, 8'h28, 8'h08, 8'h32, 8'h0D, 8'h20,
		8'hF9, 8'h2E, 8'h0F, 8'h18, 8'hF3, 8'h67, 8'h3E, 8'h64,
		8'h57, 8'hE0, 8'h42, 8'h3E, 8'h91, 8'hE0, 8'h40, 8'h04,
		8'h1E, 8'h02, 8'h0E, 8'h0C, 8'hF0, 8'h44, 8'hFE, 8'h90,
		8'h20, 8'hFA, 8'h0D, 8'h20, 8'hF7, 8'h1D, 8'h20, 8'hF2,
		8'h0E, 8'h13, 8'h24, 8'h7C, 8'h1E, 8'h83, 8'hFE, 8'h62,
		8'h28, 8'h06, 8'h1E, 8'hC1, 8'hFE, 8'h64, 8'h20, 8'h06,
		8'h7B, 8'hE2, 8'h0C, 8'h3E, 8'h87, 8'hE2, 8'hF0, 8'h42,
		8'h90, 8'hE0, 8'h42, 8'h15, 8'h20, 8'hD2, 8'h05, 8'h20,
		8'h4F, 8'h16, 8'h20, 8'h18, 8'hCB, 8'h4F, 8'h06, 8'h04,
		8'hC5, 8'hCB, 8'h11, 8'h17, 8'hC1, 8'hCB, 8'h11, 8'h17,
		8'h05, 8'h20, 8'hF5, 8'h22, 8'h23, 8'h22, 8'h23, 8'hC9,
		8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
		8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
		8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
		8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
		8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
		8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E,
		8'h3C, 8'h42, 8'hB9, 8'hA5, 8'hB9, 8'hA5, 8'h42, 8'h3C,
		8'h21, 8'h04, 8'h01, 8'h11, 8'hA8, 8'h00, 8'h1A, 8'h13,
		8'hBE, 8'h00, 8'h00, 8'h23, 8'h7D, 8'hFE, 8'h34, 8'h20,
		8'hF5, 8'h06, 8'h19, 8'h78, 8'h86, 8'h23, 8'h05, 8'h20,
		8'hFB, 8'h86, 8'h00, 8'h00, 8'h3E, 8'h01, 8'hE0, 8'h50
	};

endpackage

// ----- design/memory_map_bus_decoder.sv -----
// ----------------------------------------------------------------------------
// memory_map_bus_decoder
// Routes bus words to target units and answers local reads.
// ----------------------------------------------------------------------------
// One bus word is taken per clock: the decode is a single pass of address
// compares from the input port into the result register, so an accepted word
// is presented on the output straight from that register, and input ready stays
// high as long as the result register is empty or being taken in the same
// cycle. The overlay flag and the serial data and control registers update at
// the edge that accepts the word, so back-to-back words see each other's
// effects in order. cartridge_present resets to 1 and is written by cfg_we.
module memory_map_bus_decoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_wdata,
	input  logic            in_valid,
	output logic            in_ready,
	input  mmbd_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output mmbd_pkg::out_t  out_data
);
	import mmbd_pkg::*;

	logic       cart_present_q;
	logic       overlay_on_q;
	logic [7:0] serial_data_q;
	logic [7:0] serial_ctrl_q;
	logic       out_valid_q;
	out_t       out_data_q;

	st_t  st;
	out_t res;
	upd_t upd;
	logic in_fire;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign st.cart_present = cart_present_q;
	assign st.overlay_on   = overlay_on_q;
	assign st.ser_data     = serial_data_q;
	assign st.serial_ctrl  = serial_ctrl_q;

	mmbd_decode u_decode (
		.acc (in_data),
		.st  (st),
		.res (res),
		.upd (upd)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_present_q <= 1'b1;
		end else if (cfg_we) begin
			cart_present_q <= cfg_wdata;
		end
	end

	// Local state, updated as each word is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlay_on_q  <= 1'b1;
			serial_data_q <= 8'h00;
			serial_ctrl_q <= 8'h00;
		end else if (in_fire) begin
			if (upd.clr_overlay) begin
				overlay_on_q <= 1'b0;
			end
			if (upd.serial_data_we) begin
				serial_data_q <= in_data.write_data;
			end
			if (upd.serial_ctrl_we) begin
				serial_ctrl_q <= in_data.write_data;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- design/mmbd_decode.sv -----
// ----------------------------------------------------------------------------
// mmbd_decode
// Combinational address decode of one bus word against the local state.
// ----------------------------------------------------------------------------
module mmbd_decode (
	input  mmbd_pkg::in_t  acc,
	input  mmbd_pkg::st_t  st,
	output mmbd_pkg::out_t res,
	output mmbd_pkg::upd_t upd
);
	import mmbd_pkg::*;

	logic        wr;
	logic [15:0] a;
	logic [7:0]  d;
	logic [12:0] lo_off;

	assign wr     = (acc.opcode == OP_WRITE);
	assign a      = acc.address;
	assign d      = acc.write_data;
	assign lo_off = {5'd0, a[7:0]};

	// Region decode, priority follows the address map from the bottom up
	always_comb begin
		res = '0;
		upd = '0;
		if (a[15] == 1'b0) begin
			// Cartridge ROM, boot overlay on reads of the first page
			if (!wr && st.overlay_on && a[15:8] == 8'h00) begin
				res.local_valid     = 1'b1;
				res.local_read_data = BOOT_IMAGE[a[7:0]];
			end else if (st.cart_present) begin
				res.target_unit   = UNIT_CROM;
				res.target_offset = a[12:0];
				res.target_write  = wr;
			end else begin
				res.local_valid     = !wr;
				res.local_read_data = wr ? 8'h00 : OPEN_BUS;
			end
		end else if (a[15:13] == 3'b100) begin
			res.target_unit   = UNIT_VRAM;
			res.target_offset = a[12:0];
			res.target_write  = wr;
		end else if (a[15:13] == 3'b101) begin
			if (st.cart_present) begin
				res.target_unit   = UNIT_CRAM;
				res.target_offset = a[12:0];
				res.target_write  = wr;
			end else begin
				res.local_valid     = !wr;
				res.local_read_data = wr ? 8'h00 : OPEN_BUS;
			end
		end else if (a[15:13] == 3'b110 || a[15:9] != 7'h7F) begin
			// Work RAM and its echo below 0xFE00
			res.target_unit   = UNIT_WRAM;
			res.target_offset = a[12:0];
			res.target_write  = wr;
		end else if (a[15:8] == 8'hFE) begin
			if (a[7:0] < 8'hA0) begin
				res.target_unit   = UNIT_OAM;
				res.target_offset = lo_off;
				res.target_write  = wr;
			end else begin
				// unusable area
				res.local_valid     = !wr;
				res.local_read_data = wr ? 8'h00 : OPEN_BUS;
			end
		end else if (a[7] == 1'b0) begin
			// I/O registers 0xFF00-0xFF7F
			if (a == ADDR_SERIAL_DATA) begin
				upd.serial_data_we  = wr;
				res.local_valid     = !wr;
				res.local_read_data = wr ? 8'h00 : st.ser_data;
			end else if (a == ADDR_SERIAL_CTRL) begin
				upd.serial_ctrl_we  = wr;
				res.local_valid     = !wr;
				res.local_read_data = wr ? 8'h00 : st.serial_ctrl;
				if (wr && d == SERIAL_START) begin
					res.serial_out_valid = 1'b1;
					res.serial_out_byte  = st.ser_data;
				end
			end else if (a[7:2] == 6'b000001) begin
				res.target_unit   = UNIT_TMR;
				res.target_offset = lo_off;
				res.target_write  = wr;
			end else if (a == ADDR_INT_FLAG) begin
				res.target_unit   = UNIT_INT;
				res.target_offset = lo_off;
				res.target_write  = wr;
			end else if ((a[7:3] == 5'b01000 && a[2:0] < 3'd6) || a[7:0] == 8'h47) begin
				res.target_unit   = UNIT_VREG;
				res.target_offset = lo_off;
				res.target_write  = wr;
			end else if (a == ADDR_BOOT_OFF && wr) begin
				upd.clr_overlay = 1'b1;
			end else begin
				res.local_valid     = !wr;
				res.local_read_data = wr ? 8'h00 : OPEN_BUS;
			end
		end else if (a != ADDR_INT_ENABLE) begin
			res.target_unit   = UNIT_HRAM;
			res.target_offset = {6'd0, a[6:0]};
			res.target_write  = wr;
		end else begin
			res.target_unit   = UNIT_INT;
			res.target_offset = lo_off;
			res.target_write  = wr;
		end
	end

endmodule

// ----- design/mmbd_checker.sv -----
// ----------------------------------------------------------------------------
// mmbd_checker
// Port-level checks on the bus decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mmbd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input mmbd_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_ready,
	input mmbd_pkg::out_t out_data
);
	import mmbd_pkg::*;

	logic acc;
	assign acc = in_valid && in_ready;

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// every accepted word shows up on the next cycle
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> out_valid)
		else $error("accepted word produced no result");

	// input only stalls behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output free");

	// serial data written then started releases that byte
	a_serial: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_data.opcode == OP_WRITE && in_data.address == ADDR_SERIAL_DATA)
		##1 (acc && in_data.opcode == OP_WRITE && in_data.address == ADDR_SERIAL_CTRL
			&& in_data.write_data == SERIAL_START)
		|=> out_data.serial_out_valid && out_data.serial_out_byte == $past(in_data.write_data, 2))
		else $error("serial byte not released as written");

	// after the overlay is cleared, page zero no longer reads the boot image
	a_overlay_off: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_data.opcode == OP_WRITE && in_data.address == ADDR_BOOT_OFF)
		##1 (acc && in_data.opcode == OP_READ && in_data.address[15:8] == 8'h00)
		|=> out_data.target_unit == UNIT_CROM || out_data.local_read_data == OPEN_BUS)
		else $error("boot overlay still mapped after clear");

endmodule

bind memory_map_bus_decoder mmbd_checker u_mmbd_checker (.*);
